>>> rtl/rbl_pkg.sv
// Package for the row bucket linked lists block.
// Field widths, command and state codes, store control struct and defaults.
// No dependencies.
`default_nettype none

package rbl_pkg;

  localparam int CMD_W     = 2;
  localparam int ACTOR_W   = 6;
  localparam int Y_W       = 16;
  localparam int QROW_W    = 4;
  localparam int ROW_OUT_W = 4;
  localparam int RH_W      = 13;
  localparam int DIV_CNT_W = $clog2(Y_W);

  localparam int ROW_COUNT_DEF   = 16;
  localparam int ACTOR_COUNT_DEF = 64;

  localparam logic [RH_W-1:0] BUCKET_H_RST = RH_W'(32);

  // register index taken from paddr[2]
  localparam logic REG_BUCKET_H = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLACE     = 2'd0,
    CMD_MOVE      = 2'd1,
    CMD_READ_HEAD = 2'd2,
    CMD_READ_NEXT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_NEW,
    S_DIV_OLD,
    S_UNLINK,
    S_PUSH1,
    S_PUSH2,
    S_RD_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
    logic head_we;
  } st_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/rbl_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on rbl_pkg for the field widths.
`default_nettype none

interface rbl_in_if import rbl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ACTOR_W-1:0]   actor;
  logic [Y_W-1:0]       pos_y;
  logic [Y_W-1:0]       old_y;
  logic [QROW_W-1:0]    query_row;

  modport source (output valid, cmd, actor, pos_y, old_y, query_row, input ready);
  modport sink   (input valid, cmd, actor, pos_y, old_y, query_row, output ready);
endinterface

interface rbl_out_if import rbl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ROW_OUT_W-1:0] row_out;
  logic                 moved;
  logic                 link_valid;
  logic [ACTOR_W-1:0]   link_actor;

  modport source (output valid, row_out, moved, link_valid, link_actor, input ready);
  modport sink   (input valid, row_out, moved, link_valid, link_actor, output ready);
endinterface

`default_nettype wire

>>> rtl/row_bucket_linked_lists.sv
// Row bucket linked lists, top level.
// Depends on rbl_pkg, rbl_if, rbl_div and rbl_store.
//
// Keeps actors in doubly linked lists, one list per row of a configured height.
// in_ch takes one command item (place, move, read row head, read next of actor);
// out_ch returns exactly one result item per command. The APB port holds the
// single register, the row height, at byte address 0; pready is always high.
// All row numbers come from one shared bit-serial divider. Each command first
// divides pos_y; a read-next then reads the link memory, a place pushes the
// actor in two steps, and a move divides old_y and, if the row changes, unlinks
// the actor before the push. The divider and the single-port link memories
// set how long each command takes. in_ch.ready is high only while
// no command is in work, so the next item is accepted the cycle after the result
// is registered. A result waits in the output register while out_ch.ready is low;
// the block may accept the next item meanwhile but holds its result until the
// slot frees. Reset clears the row heads and the control state and sets the row
// height to 32; link memory entries are undefined until an actor is placed.
`default_nettype none

module row_bucket_linked_lists import rbl_pkg::*; #(
  parameter int ROW_COUNT   = ROW_COUNT_DEF,
  parameter int ACTOR_COUNT = ACTOR_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rbl_in_if.sink           in_ch,
  rbl_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(ACTOR_COUNT);
  localparam int RW = $clog2(ROW_COUNT);
  localparam int LW = AW + 1;
  localparam logic [Y_W-1:0] ROW_MAX = Y_W'(ROW_COUNT - 1);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ACTOR_W-1:0]    actor_r, actor_nxt;
  logic [Y_W-1:0]        oldy_r, oldy_nxt;
  logic [QROW_W-1:0]     qrow_r, qrow_nxt;
  logic [RW-1:0]         row_new_r, row_new_nxt;
  logic [RW-1:0]         row_old_r, row_old_nxt;
  logic [LW-1:0]         h_r, h_nxt;
  logic [LW-1:0]         lnk_r, lnk_nxt;
  logic                  moved_r, moved_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_OUT_W-1:0]  out_row_r, out_row_nxt;
  logic                  out_moved_r, out_moved_nxt;
  logic                  out_lv_r, out_lv_nxt;
  logic [ACTOR_W-1:0]    out_la_r, out_la_nxt;
  logic [RH_W-1:0]       bucket_h_r;

  logic                  in_acc;
  logic                  div_start, div_done;
  logic [Y_W-1:0]        div_dvd, div_q;
  logic [RW-1:0]         div_row;
  logic                  actor_ok, qrow_ok;
  logic [AW-1:0]         a_idx;
  logic [LW-1:0]         a_link;

  st_ctrl_t              ctrl;
  logic [AW-1:0]         next_waddr, prev_waddr;
  logic [LW-1:0]         next_wdata, prev_wdata, head_wdata;
  logic [RW-1:0]         head_waddr, head_raddr;
  logic [LW-1:0]         next_rd, prev_rd, head_rd;

  rbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (bucket_h_r),
    .done     (div_done),
    .quotient (div_q)
  );

  rbl_store #(
    .ROW_COUNT   (ROW_COUNT),
    .ACTOR_COUNT (ACTOR_COUNT)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .rd_addr    (a_idx),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_raddr (head_raddr),
    .next_rd    (next_rd),
    .prev_rd    (prev_rd),
    .head_rd    (head_rd)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_H) ? {(32 - RH_W)'(0), bucket_h_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_h_r <= BUCKET_H_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUCKET_H)) begin
      bucket_h_r <= pwdata[RH_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign actor_ok = 32'(actor_r) < 32'(ACTOR_COUNT);
  assign qrow_ok  = 32'(qrow_r) < 32'(ROW_COUNT);
  assign a_idx    = AW'(actor_r);
  assign a_link   = {1'b1, a_idx};
  assign div_row  = (div_q > ROW_MAX) ? RW'(ROW_MAX) : RW'(div_q);
  assign div_dvd  = (state_r == S_IDLE) ? in_ch.pos_y : oldy_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    actor_nxt     = actor_r;
    oldy_nxt      = oldy_r;
    qrow_nxt      = qrow_r;
    row_new_nxt   = row_new_r;
    row_old_nxt   = row_old_r;
    h_nxt         = h_r;
    lnk_nxt       = lnk_r;
    moved_nxt     = moved_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_moved_nxt = out_moved_r;
    out_lv_nxt    = out_lv_r;
    out_la_nxt    = out_la_r;
    div_start     = 1'b0;
    ctrl          = '0;
    next_waddr    = a_idx;
    next_wdata    = '0;
    prev_waddr    = a_idx;
    prev_wdata    = '0;
    head_waddr    = row_new_r;
    head_wdata    = a_link;
    head_raddr    = (state_r == S_PUSH1) ? row_new_r : RW'(qrow_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = cmd_t'(in_ch.cmd);
          actor_nxt = in_ch.actor;
          oldy_nxt  = in_ch.old_y;
          qrow_nxt  = in_ch.query_row;
          moved_nxt = 1'b0;
          lnk_nxt   = '0;
          div_start = 1'b1;
          state_nxt = S_DIV_NEW;
        end
      end
      S_DIV_NEW: begin
        if (div_done) begin
          row_new_nxt = div_row;
          unique case (cmd_r)
            CMD_PLACE: begin
              state_nxt = actor_ok ? S_PUSH1 : S_DONE;
            end
            CMD_MOVE: begin
              if (actor_ok) begin
                div_start = 1'b1;
                state_nxt = S_DIV_OLD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_READ_HEAD: begin
              lnk_nxt   = qrow_ok ? head_rd : '0;
              state_nxt = S_DONE;
            end
            CMD_READ_NEXT: begin
              if (actor_ok) begin
                ctrl.rd_en = 1'b1;
                state_nxt  = S_RD_NEXT;
              end else begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end
      S_DIV_OLD: begin
        if (div_done) begin
          row_old_nxt = div_row;
          if (div_row != row_new_r) begin
            ctrl.rd_en = 1'b1;
            moved_nxt  = 1'b1;
            state_nxt  = S_UNLINK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_UNLINK: begin
        // prev_rd and next_rd hold the actor's own links
        ctrl.prev_we = next_rd[LW-1];
        prev_waddr   = next_rd[AW-1:0];
        prev_wdata   = prev_rd[LW-1] ? prev_rd : '0;
        next_waddr   = prev_rd[AW-1:0];
        next_wdata   = next_rd[LW-1] ? next_rd : '0;
        head_waddr   = row_old_r;
        head_wdata   = next_rd[LW-1] ? next_rd : '0;
        ctrl.next_we = prev_rd[LW-1];
        ctrl.head_we = !prev_rd[LW-1];
        state_nxt    = S_PUSH1;
      end
      S_PUSH1: begin
        h_nxt        = head_rd;
        ctrl.prev_we = 1'b1;
        prev_wdata   = '0;
        ctrl.next_we = 1'b1;
        next_wdata   = head_rd[LW-1] ? head_rd : '0;
        ctrl.head_we = 1'b1;
        head_wdata   = a_link;
        state_nxt    = S_PUSH2;
      end
      S_PUSH2: begin
        ctrl.prev_we = h_r[LW-1];
        prev_waddr   = h_r[AW-1:0];
        prev_wdata   = a_link;
        state_nxt    = S_DONE;
      end
      S_RD_NEXT: begin
        lnk_nxt   = next_rd;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = ROW_OUT_W'(row_new_r);
          out_moved_nxt = moved_r;
          out_lv_nxt    = lnk_r[LW-1];
          out_la_nxt    = lnk_r[LW-1] ? ACTOR_W'(lnk_r[AW-1:0]) : '0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    actor_r     <= actor_nxt;
    oldy_r      <= oldy_nxt;
    qrow_r      <= qrow_nxt;
    row_new_r   <= row_new_nxt;
    row_old_r   <= row_old_nxt;
    h_r         <= h_nxt;
    lnk_r       <= lnk_nxt;
    moved_r     <= moved_nxt;
    out_row_r   <= out_row_nxt;
    out_moved_r <= out_moved_nxt;
    out_lv_r    <= out_lv_nxt;
    out_la_r    <= out_la_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_out    = out_row_r;
  assign out_ch.moved      = out_moved_r;
  assign out_ch.link_valid = out_lv_r;
  assign out_ch.link_actor = out_la_r;

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DIV_NEW))
    else $error("accepted item did not start the row division");

  a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_NEW || state_r == S_DIV_OLD))
    else $error("divider finished outside a division state");

  a_moved_no_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_moved_r && out_lv_r))
    else $error("result marks both a move and a read link");

  a_row_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (32'(row_new_r) < 32'(ROW_COUNT)))
    else $error("row beyond the last bucket");

  a_store_single_head_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.head_we |-> (state_r == S_UNLINK || state_r == S_PUSH1))
    else $error("row head written outside unlink or push");

endmodule

`default_nettype wire

>>> rtl/rbl_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on rbl_pkg for widths.
`default_nettype none

module rbl_div import rbl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [Y_W-1:0]   dividend,
  input  wire logic [RH_W-1:0]  divisor,
  output logic                  done,
  output logic [Y_W-1:0]        quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Y_W-1:0]       dvd_r, dvd_nxt;
  logic [RH_W-1:0]      rem_r, rem_nxt;
  logic [RH_W:0]        rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[Y_W-1]};
    fits     = rem_sh >= {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    done_nxt = busy_r && (cnt_r == '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(Y_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[Y_W-2:0], fits};
      rem_nxt = fits ? RH_W'(rem_sh - {1'b0, divisor}) : RH_W'(rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

>>> rtl/rbl_store.sv
// Link store: row head registers with valid bits, next and prev link memories.
// Depends on rbl_pkg for the control struct.
`default_nettype none

module rbl_store import rbl_pkg::*; #(
  parameter  int ROW_COUNT   = ROW_COUNT_DEF,
  parameter  int ACTOR_COUNT = ACTOR_COUNT_DEF,
  localparam int AW          = $clog2(ACTOR_COUNT),
  localparam int RW          = $clog2(ROW_COUNT),
  localparam int LW          = AW + 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire st_ctrl_t      ctrl,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] next_waddr,
  input  wire logic [LW-1:0] next_wdata,
  input  wire logic [AW-1:0] prev_waddr,
  input  wire logic [LW-1:0] prev_wdata,
  input  wire logic [RW-1:0] head_waddr,
  input  wire logic [LW-1:0] head_wdata,
  input  wire logic [RW-1:0] head_raddr,
  output logic [LW-1:0]      next_rd,
  output logic [LW-1:0]      prev_rd,
  output logic [LW-1:0]      head_rd
);

  logic [LW-1:0] next_mem [ACTOR_COUNT];
  logic [LW-1:0] prev_mem [ACTOR_COUNT];
  logic [LW-1:0] head_r   [ROW_COUNT];
  logic [LW-1:0] next_rd_r;
  logic [LW-1:0] prev_rd_r;

  always_ff @(posedge clk) begin
    if (ctrl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctrl.rd_en) begin
      next_rd_r <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctrl.rd_en) begin
      prev_rd_r <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        head_r[i] <= '0;
      end
    end else if (ctrl.head_we) begin
      head_r[head_waddr] <= head_wdata;
    end
  end

  assign next_rd = next_rd_r;
  assign prev_rd = prev_rd_r;
  assign head_rd = head_r[head_raddr];

endmodule

`default_nettype wire

>>> bench/tb_row_bucket_linked_lists.sv
`timescale 1ns / 1ps
// Testbench for row_bucket_linked_lists: random valid/ready traffic with idling on both sides,
// APB writes of the row height between phases and a scoreboard class with its own list model.
// Depends on rbl_pkg, rbl_if and the block's RTL.

module tb_row_bucket_linked_lists import rbl_pkg::*; ();

  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          PHASES        = 9;
  localparam int          PHASE_ITEMS   = 150;
  localparam logic [2:0]  BUCKET_H_ADDR = {REG_BUCKET_H, 2'b00};

  typedef struct packed {
    cmd_t               cmd;
    logic [ACTOR_W-1:0] actor;
    logic [Y_W-1:0]     pos_y;
    logic [Y_W-1:0]     old_y;
    logic [QROW_W-1:0]  query_row;
  } command_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row_out;
    logic                 moved;
    logic                 link_valid;
    logic [ACTOR_W-1:0]   link_actor;
  } result_t;

  typedef struct packed {
    logic               vld;
    logic [ACTOR_W-1:0] idx;
  } link_t;

  class row_list_scoreboard;
    logic [RH_W-1:0] height;
    link_t           head[ROW_COUNT_DEF];
    link_t           next_of[ACTOR_COUNT_DEF];
    link_t           prev_of[ACTOR_COUNT_DEF];
    result_t         pending_results[$];
    int              failures;
    int              row_changes;

    function new();
      height = BUCKET_H_RST;
      foreach (head[i]) head[i] = '0;
      foreach (next_of[i]) next_of[i] = '0;
      foreach (prev_of[i]) prev_of[i] = '0;
      failures = 0;
      row_changes = 0;
    endfunction

    function logic [ROW_OUT_W-1:0] row_for(logic [Y_W-1:0] y);
      int unsigned r;
      if (height == 0) return ROW_OUT_W'(ROW_COUNT_DEF - 1);
      r = 32'(y) / 32'(height);
      if (r > ROW_COUNT_DEF - 1) r = ROW_COUNT_DEF - 1;
      return ROW_OUT_W'(r);
    endfunction

    function void unlink(logic [ACTOR_W-1:0] a, logic [ROW_OUT_W-1:0] row);
      link_t p;
      link_t n;
      p = prev_of[a];
      n = next_of[a];
      if (n.vld) prev_of[n.idx] = p.vld ? p : '0;
      if (p.vld) next_of[p.idx] = n.vld ? n : '0;
      else head[row] = n.vld ? n : '0;
    endfunction

    function void push(logic [ACTOR_W-1:0] a, logic [ROW_OUT_W-1:0] row);
      link_t h;
      h = head[row];
      prev_of[a] = '0;
      if (h.vld) begin
        prev_of[h.idx] = '{vld: 1'b1, idx: a};
        next_of[a] = h;
      end else begin
        next_of[a] = '0;
      end
      head[row] = '{vld: 1'b1, idx: a};
    endfunction

    function void predict_command(command_t c);
      logic [ROW_OUT_W-1:0] row;
      logic [ROW_OUT_W-1:0] from_row;
      logic                 moved;
      link_t                lk;
      result_t              want;
      row = row_for(c.pos_y);
      moved = 1'b0;
      lk = '0;
      case (c.cmd)
        CMD_PLACE: push(c.actor, row);
        CMD_MOVE: begin
          from_row = row_for(c.old_y);
          if (from_row != row) begin
            unlink(c.actor, from_row);
            push(c.actor, row);
            moved = 1'b1;
            row_changes++;
          end
        end
        CMD_READ_HEAD: lk = head[c.query_row];
        default: lk = next_of[c.actor];
      endcase
      want.row_out    = row;
      want.moved      = moved;
      want.link_valid = lk.vld;
      want.link_actor = lk.vld ? lk.idx : '0;
      pending_results.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no command waiting: row_out %0d moved %0d link %0d/%0d",
               got.row_out, got.moved, got.link_valid, got.link_actor);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.row_out !== want.row_out) begin
        $error("row_out: expected %0d, got %0d", want.row_out, got.row_out);
        failures++;
      end
      if (got.moved !== want.moved) begin
        $error("moved: expected %0d, got %0d", want.moved, got.moved);
        failures++;
      end
      if (got.link_valid !== want.link_valid) begin
        $error("link_valid: expected %0d, got %0d", want.link_valid, got.link_valid);
        failures++;
      end
      if (got.link_actor !== want.link_actor) begin
        $error("link_actor: expected %0d, got %0d", want.link_actor, got.link_actor);
        failures++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rbl_in_if  cmd_bus ();
  rbl_out_if res_bus ();

  row_list_scoreboard sb = new();

  int             cycle_count = 0;
  int             send_gap = 0;
  bit             no_idle = 1'b0;
  int             n_items = 0;
  int             n_heights = 0;
  int             bus_errors = 0;
  int             n_on_stage = 0;
  bit             on_stage[ACTOR_COUNT_DEF];
  logic [Y_W-1:0] cur_y[ACTOR_COUNT_DEF];

  row_bucket_linked_lists u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_bus),
    .out_ch  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic command_t cmd_item(cmd_t c, int a, int y, int oy, int q);
    command_t it;
    it.cmd       = c;
    it.actor     = ACTOR_W'(a);
    it.pos_y     = Y_W'(y);
    it.old_y     = Y_W'(oy);
    it.query_row = QROW_W'(q);
    return it;
  endfunction

  function automatic logic [Y_W-1:0] gen_y();
    int unsigned h;
    int unsigned y;
    h = 32'(sb.height);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return Y_W'($urandom_range(0, 65535));
      default: begin
        if (h == 0) return Y_W'($urandom_range(0, 65535));
        y = $urandom_range(0, 15) * h + $urandom_range(0, h - 1);
        return (y > 65535) ? '1 : Y_W'(y);
      end
    endcase
  endfunction

  function automatic int pick_placed();
    int a;
    do a = $urandom_range(0, ACTOR_COUNT_DEF - 1); while (!on_stage[a]);
    return a;
  endfunction

  function automatic int pick_unplaced();
    int a;
    do a = $urandom_range(0, ACTOR_COUNT_DEF - 1); while (on_stage[a]);
    return a;
  endfunction

  function automatic int any_y();
    return $urandom_range(0, 65535);
  endfunction

  task automatic drive_cmd(command_t it);
    repeat (send_gap) @(posedge clk);
    cmd_bus.valid     <= 1'b1;
    cmd_bus.cmd       <= it.cmd;
    cmd_bus.actor     <= it.actor;
    cmd_bus.pos_y     <= it.pos_y;
    cmd_bus.old_y     <= it.old_y;
    cmd_bus.query_row <= it.query_row;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    sb.predict_command(it);
    n_items++;
    if (it.cmd == CMD_PLACE && !on_stage[it.actor]) begin
      on_stage[it.actor] = 1'b1;
      n_on_stage++;
    end
    if (it.cmd == CMD_PLACE || it.cmd == CMD_MOVE) cur_y[it.actor] = it.pos_y;
    send_gap = no_idle ? 0 : $urandom_range(0, 3);
    if (send_gap != 0) cmd_bus.valid <= 1'b0;
  endtask

  task automatic settle();
    if (send_gap == 0) cmd_bus.valid <= 1'b0;
    send_gap = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bucket_h(logic [RH_W-1:0] h);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKET_H_ADDR;
    pwdata  <= 32'(h);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.height = h;
    n_heights++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(h)) begin
      $error("row height readback: expected %0d, got %0d", h, prdata);
      bus_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic walk_row();
    int    steps;
    int    row;
    link_t lk;
    row = $urandom_range(0, ROW_COUNT_DEF - 1);
    steps = $urandom_range(0, 6);
    drive_cmd(cmd_item(CMD_READ_HEAD, $urandom_range(0, 63), any_y(), any_y(), row));
    lk = sb.head[row];
    while (steps > 0 && lk.vld) begin
      drive_cmd(cmd_item(CMD_READ_NEXT, lk.idx, any_y(), any_y(), $urandom_range(0, 15)));
      lk = sb.next_of[lk.idx];
      steps--;
    end
  endtask

  task automatic random_phase(int target);
    int start;
    int r;
    int a;
    start = n_items;
    while (n_items - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 14 && n_on_stage < ACTOR_COUNT_DEF) begin
        drive_cmd(cmd_item(CMD_PLACE, pick_unplaced(), gen_y(), any_y(), any_y()));
      end else if (r < 56) begin
        a = pick_placed();
        drive_cmd(cmd_item(CMD_MOVE, a, gen_y(),
                           ($urandom_range(0, 9) == 0) ? any_y() : cur_y[a], any_y()));
      end else if (r < 62) begin
        a = pick_placed();
        drive_cmd(cmd_item(CMD_MOVE, a, cur_y[a], cur_y[a], any_y()));
      end else if (r < 84) begin
        walk_row();
      end else if (r < 89) begin
        drive_cmd(cmd_item(CMD_READ_NEXT, pick_placed(), any_y(), any_y(), any_y()));
      end else if (r < 94) begin
        drive_cmd(cmd_item(CMD_READ_HEAD, $urandom_range(0, 63), any_y(), any_y(),
                           $urandom_range(0, 15)));
      end else begin
        drive_cmd(cmd_item(CMD_PLACE, pick_placed(), gen_y(), any_y(), any_y()));
      end
      if ($urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    int      gap;
    result_t got;
    res_bus.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    gap = 0;
    forever begin
      repeat (gap) @(posedge clk);
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (res_bus.valid !== 1'b1);
      got.row_out    = res_bus.row_out;
      got.moved      = res_bus.moved;
      got.link_valid = res_bus.link_valid;
      got.link_actor = res_bus.link_actor;
      sb.check_result(got);
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) res_bus.ready <= 1'b0;
    end
  end

  initial begin
    logic [RH_W-1:0] h;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.cmd       = CMD_PLACE;
    cmd_bus.actor     = '0;
    cmd_bus.pos_y     = '0;
    cmd_bus.old_y     = '0;
    cmd_bus.query_row = '0;
    foreach (on_stage[i]) on_stage[i] = 1'b0;
    foreach (cur_y[i]) cur_y[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 0));
    drive_cmd(cmd_item(CMD_READ_HEAD, 63, 65535, 65535, 15));
    drive_cmd(cmd_item(CMD_PLACE, 0, 0, 65535, 15));
    drive_cmd(cmd_item(CMD_PLACE, 63, 65535, 0, 0));
    drive_cmd(cmd_item(CMD_PLACE, 1, 31, 0, 0));
    drive_cmd(cmd_item(CMD_PLACE, 2, 32, 0, 0));
    drive_cmd(cmd_item(CMD_READ_HEAD, 5, 0, 0, 0));
    drive_cmd(cmd_item(CMD_READ_NEXT, 1, 0, 0, 0));
    drive_cmd(cmd_item(CMD_READ_NEXT, 0, 0, 0, 0));
    drive_cmd(cmd_item(CMD_MOVE, 0, 40, 0, 0));
    drive_cmd(cmd_item(CMD_MOVE, 1, 5, 31, 0));
    drive_cmd(cmd_item(CMD_MOVE, 2, 65535, 32, 0));
    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 15));
    drive_cmd(cmd_item(CMD_READ_NEXT, 2, 0, 0, 0));
    drive_cmd(cmd_item(CMD_READ_NEXT, 63, 0, 0, 0));
    // place an actor that is still listed elsewhere
    drive_cmd(cmd_item(CMD_PLACE, 0, 100, 0, 0));
    // move with an old position from the wrong row
    drive_cmd(cmd_item(CMD_MOVE, 63, 64, 0, 0));
    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 1));
    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 2));
    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 3));
    drive_cmd(cmd_item(CMD_MOVE, 2, 0, 65535, 0));
    drive_cmd(cmd_item(CMD_READ_NEXT, 2, 0, 0, 0));
    drive_cmd(cmd_item(CMD_READ_HEAD, 0, 0, 0, 15));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: h = RH_W'(1);
        1: h = RH_W'(4096);
        2: h = '0;
        3: h = RH_W'(8191);
        4: h = RH_W'($urandom_range(2, 64));
        5: h = RH_W'($urandom_range(65, 4096));
        6: h = RH_W'($urandom_range(1, 8191));
        7: h = RH_W'(500);
        default: h = RH_W'($urandom_range(2, 300));
      endcase
      write_bucket_h(h);
      no_idle = (ph % 3 == 1);
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (50) @(posedge clk);
    $display("Run covered %0d commands, %0d of them moves that changed row,",
             n_items, sb.row_changes);
    $display("under %0d row height settings from 0 up to 8191.", n_heights + 1);
    if (sb.failures == 0 && bus_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rbl_pkg.sv
rtl/rbl_if.sv
rtl/rbl_div.sv
rtl/rbl_store.sv
rtl/row_bucket_linked_lists.sv
bench/tb_row_bucket_linked_lists.sv
